// ===== src/bracket_range_balance_tree_defines.svh =====
// assertion macros for the bracket range balance tree
`ifndef BRACKET_RANGE_BALANCE_TREE_DEFINES_SVH
`define BRACKET_RANGE_BALANCE_TREE_DEFINES_SVH

`define BRBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BRBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/brbt_pkg.sv =====
`default_nettype none
package brbt_pkg;
    localparam int unsigned PosW = 11;
    localparam int unsigned CntOutMax = 2047;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op            op;
        logic           is_open;
        logic [PosW-1:0] left_pos;
        logic [PosW-1:0] right_pos;
        logic           range_error;
    } t_req;

    typedef struct packed {
        logic [PosW-1:0] unmatched_close;
        logic [PosW-1:0] unmatched_open;
        logic            balanced;
        logic            range_error;
    } t_res;
endpackage
`default_nettype wire

// ===== src/brbt_ram.sv =====
`default_nettype none
module brbt_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/brbt_front.sv =====
`default_nettype none
module brbt_front
    import brbt_pkg::*;
#(
    parameter int unsigned MaxLen = 1024
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    output logic              o_full,
    input  wire               i_operation,
    input  wire               i_is_open,
    input  wire  [PosW-1:0]   i_left_pos,
    input  wire  [PosW-1:0]   i_right_pos,
    input  wire  [PosW-1:0]   i_len,
    output logic              o_req_valid,
    output t_req              o_req,
    input  wire               i_req_pop
);
    localparam int unsigned LenW = $clog2(MaxLen + 1);
    localparam int unsigned ExtW = (LenW > PosW) ? LenW : PosW;

    t_req r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [ExtW-1:0] w_len, w_lp, w_rp;
    logic w_cap, w_bad;
    t_req w_in;

    assign w_cap = ExtW'(i_len) > ExtW'(MaxLen);
    assign w_len = w_cap ? ExtW'(MaxLen) : ExtW'(i_len);
    assign w_lp = ExtW'(i_left_pos);
    assign w_rp = ExtW'(i_right_pos);

    always_comb begin
        if (i_operation == OP_WRITE) begin
            w_bad = (w_lp == '0) || (w_lp > w_len);
        end else begin
            w_bad = (w_lp == '0) || (w_lp > w_rp) || (w_rp > w_len);
        end
        w_in.op = t_op'(i_operation);
        w_in.is_open = i_is_open;
        w_in.left_pos = i_left_pos;
        w_in.right_pos = i_right_pos;
        w_in.range_error = w_bad;
    end

    assign o_full = r_cnt[1];
    assign o_req_valid = r_cnt != 2'd0;
    assign o_req = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_q[r_wp] <= w_in;
                r_wp <= ~r_wp;
            end
            if (i_req_pop && o_req_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_req_pop && o_req_valid) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

// ===== src/brbt_back.sv =====
`default_nettype none
module brbt_back
    import brbt_pkg::*;
#(
    parameter int unsigned MaxLen = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_req_valid,
    input  wire t_req    i_req,
    output logic         o_req_pop,
    output logic         o_empty,
    input  wire          i_pop,
    output t_res         o_res
);
    localparam int unsigned Depth = 2 * MaxLen;
    localparam int unsigned AW = $clog2(Depth);
    localparam int unsigned CW = $clog2(MaxLen + 1);
    localparam int unsigned NW = 2 * CW;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_UP_RD, S_UP_WAIT, S_UP_WR, S_Q_STEP, S_Q_WAIT, S_DONE
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_idx, r_lo, r_hi;
    logic [CW-1:0] r_lc, r_lo_c, r_rc, r_ro_c;
    logic [CW-1:0] r_ac, r_ao;
    logic r_sel_r;
    t_res r_res;
    logic r_full;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [NW-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0] w_rc, w_ro;

    brbt_ram #(.Width(NW), .Depth(Depth)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    assign w_rc = ram_rdata[NW-1:CW];
    assign w_ro = ram_rdata[CW-1:0];

    function automatic logic [NW-1:0] join_f(input logic [CW-1:0] ac, input logic [CW-1:0] ao,
                                             input logic [CW-1:0] bc, input logic [CW-1:0] bo);
        logic [NW-1:0] r;
        if (ao >= bc) begin
            r = {ac, bo + (ao - bc)};
        end else begin
            r = {ac + (bc - ao), bo};
        end
        return r;
    endfunction

    logic [NW-1:0] w_join;
    logic [CW-1:0] w_sat_c, w_sat_o;
    logic [NW-1:0] w_tot;

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_idx;
        w_join = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_UP_RD, S_UP_WAIT: begin
                ram_raddr = r_idx ^ AW'(1);
            end
            S_UP_WR: begin
                if (r_idx[0]) begin
                    w_join = join_f(w_rc, w_ro, r_ac, r_ao);
                end else begin
                    w_join = join_f(r_ac, r_ao, w_rc, w_ro);
                end
                ram_we = 1'b1;
                ram_waddr = r_idx >> 1;
                ram_wdata = w_join;
            end
            S_Q_STEP: begin
                ram_raddr = r_sel_r ? r_hi : r_lo;
            end
            default: begin
            end
        endcase
        if (r_state == S_IDLE && i_req_valid && !r_full && i_req.op == OP_WRITE &&
            !i_req.range_error) begin
            ram_we = 1'b1;
            ram_waddr = AW'(MaxLen) + AW'(i_req.left_pos) - AW'(1);
            ram_wdata = i_req.is_open ? {CW'(0), CW'(1)} : {CW'(1), CW'(0)};
        end
    end

    assign w_tot = join_f(r_lc, r_lo_c, r_rc, r_ro_c);
    assign w_sat_c = (w_tot[NW-1:CW] > CW'(CntOutMax)) ? CW'(CntOutMax) : w_tot[NW-1:CW];
    assign w_sat_o = (w_tot[CW-1:0] > CW'(CntOutMax)) ? CW'(CntOutMax) : w_tot[CW-1:0];

    assign o_req_pop = (r_state == S_IDLE) && i_req_valid && !r_full;
    assign o_empty = !r_full;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= '0;
            r_full <= 1'b0;
        end else begin
            if (i_pop && r_full) begin
                r_full <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == AW'(Depth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid && !r_full) begin
                        if (i_req.op == OP_WRITE) begin
                            if (!i_req.range_error) begin
                                r_idx <= AW'(MaxLen) + AW'(i_req.left_pos) - AW'(1);
                                r_ac <= i_req.is_open ? CW'(0) : CW'(1);
                                r_ao <= i_req.is_open ? CW'(1) : CW'(0);
                                r_state <= S_UP_RD;
                            end
                        end else if (i_req.range_error) begin
                            r_res <= '{unmatched_close: '0, unmatched_open: '0,
                                       balanced: 1'b0, range_error: 1'b1};
                            r_full <= 1'b1;
                        end else begin
                            r_lo <= AW'(MaxLen) + AW'(i_req.left_pos) - AW'(1);
                            r_hi <= AW'(MaxLen) + AW'(i_req.right_pos) - AW'(1);
                            r_lc <= '0; r_lo_c <= '0; r_rc <= '0; r_ro_c <= '0;
                            r_sel_r <= 1'b0;
                            r_state <= S_Q_STEP;
                        end
                    end
                end
                S_UP_RD: r_state <= S_UP_WAIT;
                S_UP_WAIT: r_state <= S_UP_WR;
                S_UP_WR: begin
                    r_ac <= w_join[NW-1:CW];
                    r_ao <= w_join[CW-1:0];
                    r_idx <= r_idx >> 1;
                    r_state <= ((r_idx >> 1) == AW'(1)) ? S_IDLE : S_UP_RD;
                end
                // closed interval [lo,hi]; take lo if odd (right child), hi if even
                S_Q_STEP: begin
                    if (r_lo > r_hi) begin
                        r_state <= S_DONE;
                    end else if (!r_sel_r && !r_lo[0] && r_lo != r_hi) begin
                        r_sel_r <= 1'b1;
                        if (r_hi[0]) begin
                            r_lo <= r_lo >> 1;
                            r_hi <= r_hi >> 1;
                            r_sel_r <= 1'b0;
                        end
                    end else begin
                        r_state <= S_Q_WAIT;
                    end
                end
                S_Q_WAIT: begin
                    if (!r_sel_r) begin
                        {r_lc, r_lo_c} <= join_f(r_lc, r_lo_c, w_rc, w_ro);
                        if (r_lo == r_hi) begin
                            r_state <= S_DONE;
                        end else begin
                            r_lo <= r_lo + AW'(1);
                            r_state <= S_Q_STEP;
                        end
                    end else begin
                        {r_rc, r_ro_c} <= join_f(w_rc, w_ro, r_rc, r_ro_c);
                        r_lo <= r_lo >> 1;
                        r_hi <= (r_hi - AW'(1)) >> 1;
                        r_sel_r <= 1'b0;
                        r_state <= S_Q_STEP;
                    end
                end
                S_DONE: begin
                    r_res <= '{unmatched_close: PosW'(w_sat_c), unmatched_open: PosW'(w_sat_o),
                               balanced: w_tot[NW-1:CW] == w_tot[CW-1:0],
                               range_error: 1'b0};
                    r_full <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/bracket_range_balance_tree.sv =====
// Segment tree over up to MaxLen bracket positions. Writes update a leaf and
// its ancestors, stepping through S_UP_RD, S_UP_WAIT and S_UP_WR at each tree
// level (log2 MaxLen levels); queries walk the range one tree-memory read at a
// time, up to two nodes per level. A new request is taken only in S_IDLE with
// the result register empty, so requests do not overlap. After reset all
// 2*MaxLen tree-memory words are cleared before requests are taken.
`default_nettype none
module bracket_range_balance_tree
    import brbt_pkg::*;
#(
    parameter int unsigned MaxLen = 1024
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    output logic             o_full,
    input  wire              i_operation,
    input  wire              i_is_open,
    input  wire  [PosW-1:0]  i_left_pos,
    input  wire  [PosW-1:0]  i_right_pos,
    output logic             o_empty,
    input  wire              i_pop,
    output logic [PosW-1:0]  o_unmatched_close,
    output logic [PosW-1:0]  o_unmatched_open,
    output logic             o_balanced,
    output logic             o_range_error,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [1:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [PosW-1:0] r_seq_length;
    logic req_valid, req_pop;
    t_req req;
    t_res res;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(r_seq_length) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_length <= PosW'(1024);
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_seq_length <= pwdata[PosW-1:0];
        end
    end

    brbt_front #(.MaxLen(MaxLen)) u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_operation, .i_is_open,
        .i_left_pos, .i_right_pos, .i_len(r_seq_length),
        .o_req_valid(req_valid), .o_req(req), .i_req_pop(req_pop)
    );

    brbt_back #(.MaxLen(MaxLen)) u_back (
        .i_clk, .i_rst_n, .i_req_valid(req_valid), .i_req(req), .o_req_pop(req_pop),
        .o_empty, .i_pop, .o_res(res)
    );

    assign o_unmatched_close = res.unmatched_close;
    assign o_unmatched_open = res.unmatched_open;
    assign o_balanced = res.balanced;
    assign o_range_error = res.range_error;
endmodule
`default_nettype wire

// ===== src/brbt_checker.sv =====
`default_nettype none
`include "bracket_range_balance_tree_defines.svh"
module brbt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_empty,
    input wire        i_pop,
    input wire [10:0] o_unmatched_close,
    input wire [10:0] o_unmatched_open,
    input wire        o_balanced,
    input wire        o_range_error
);
    `BRBT_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, !o_empty && o_range_error, o_unmatched_close == 11'd0 && o_unmatched_open == 11'd0 && !o_balanced)
    `BRBT_ASSERT_IMPL(a_bal, i_clk, i_rst_n, !o_empty && !o_range_error && o_unmatched_close != o_unmatched_open, !o_balanced)
    `BRBT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_unmatched_close))
endmodule

bind bracket_range_balance_tree brbt_checker u_chk (.*);
`default_nettype wire
